// ----- design/table_linear_interp_extrap_top_assert.svh -----
// Assertion macros for the table interpolator top level.
// Needs clk and rst_n in the scope where a macro is used.
`ifndef TABLE_LINEAR_INTERP_EXTRAP_TOP_ASSERT_SVH
`define TABLE_LINEAR_INTERP_EXTRAP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define TLIE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define TLIE_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define TLIE_ASSERT(lbl, prop, msg)
`define TLIE_NEVER(lbl, expr, msg)
`endif
`endif

// ----- design/lintp_pkg.sv -----
// Shared types and constants of the table interpolator.
// No dependencies.
package lintp_pkg;

  localparam int CFG_W     = 7;
  localparam int ROW_W     = 6;
  localparam int NUM_W     = 32;  // dividend: |dx| << 16 plus half the divisor
  localparam int DEN_W     = 16;  // |x1 - x0|
  localparam int DIV_CNT_W = 6;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = 1;
  localparam int QCNT_W    = 2;
  localparam int T_W       = NUM_W + 1;
  localparam int PROD_W    = T_W + 17;
  localparam int Y_W       = 36;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef logic signed [15:0] q16_t;
  typedef q16_t [3:0] vals_t;

  typedef struct packed {
    logic             is_query;
    logic [ROW_W-1:0] row_index;
    q16_t             breakpoint_angle;
    vals_t            vals;
    q16_t             query_angle;
  } item_t;

  typedef struct packed {
    vals_t vals;
    logic  saturated;
    logic  extrapolated;
  } res_t;

  typedef struct packed {
    logic full;
  } front_stat_t;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quo;
  } div_rsp_t;

  typedef enum logic [3:0] {
    B_IDLE, B_FIRST, B_LAST, B_SCAN, B_FETCH0, B_FETCH1, B_FETCH2,
    B_DIV, B_MUL, B_ACC, B_DONE
  } back_state_t;

endpackage

// ----- design/lintp_if.sv -----
// Valid/ready channel interfaces for input items and results.
// No dependencies.
interface lintp_in_if;
  logic              valid;
  logic              ready;
  logic              op;
  logic [5:0]        row_index;
  logic signed [15:0] breakpoint_angle;
  logic signed [15:0] main_lift_value;
  logic signed [15:0] main_drag_value;
  logic signed [15:0] back_lift_value;
  logic signed [15:0] back_drag_value;
  logic signed [15:0] query_angle;
  modport source (output valid, op, row_index, breakpoint_angle, main_lift_value,
                  main_drag_value, back_lift_value, back_drag_value, query_angle,
                  input ready);
  modport sink (input valid, op, row_index, breakpoint_angle, main_lift_value,
                main_drag_value, back_lift_value, back_drag_value, query_angle,
                output ready);
endinterface

interface lintp_out_if;
  logic              valid;
  logic              ready;
  logic signed [15:0] main_lift;
  logic signed [15:0] main_drag;
  logic signed [15:0] back_lift;
  logic signed [15:0] back_drag;
  logic              saturated;
  logic              extrapolated;
  modport source (output valid, main_lift, main_drag, back_lift, back_drag,
                  saturated, extrapolated, input ready);
  modport sink (input valid, main_lift, main_drag, back_lift, back_drag,
                saturated, extrapolated, output ready);
endinterface

// ----- design/table_linear_interp_extrap_top.sv -----
// Piecewise-linear lookup over a four-column breakpoint table.
// Input channel in_ch: op 0 loads one table row, op 1 queries at an angle.
// Every input transaction returns exactly one result on out_ch, in order;
// a row load returns an all-zero acknowledgement.
// cfg_we/cfg_wdata set points_in_use; write it only while the block is idle.
// A row load goes from acceptance through B_DONE into the output register.
// A query at or beyond an end of the span skips the segment scan; inside the span
// the scan reads one table row per cycle and stops at the upper row of the
// segment, index 1 to MAX_POINTS - 1. A segment with equal breakpoints skips
// the divider. Query time is set by the 32-step serial fraction divider and
// the linear scan on the single table read port.
// Items are handled one at a time; a two-entry queue ahead of the engine
// keeps in_ch.ready high until two further transactions wait.
// When out_ch stalls, the result holds in the output register and the
// engine waits; the queue keeps accepting until full.
// Reset clears control state and sets points_in_use to 2; table contents
// are undefined until written, and no clearing pass runs.
// Depends on lintp_pkg, lintp_if, lintp_front, lintp_div and lintp_back.
`include "table_linear_interp_extrap_top_assert.svh"
module table_linear_interp_extrap_top #(
  parameter int MAX_POINTS = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  lintp_in_if.sink                    in_ch,
  lintp_out_if.source                 out_ch,
  input  logic                        cfg_we,
  input  logic [lintp_pkg::CFG_W-1:0] cfg_wdata
);
  import lintp_pkg::*;

  logic [CFG_W-1:0] cfg_points_r, cfg_points_nxt;
  logic             q_valid;
  logic             q_pop;
  item_t            q_item;
  front_stat_t      fr_stat;
  div_req_t         div_req;
  div_rsp_t         div_rsp;
  logic             any_rail;

  assign cfg_points_nxt = cfg_we ? cfg_wdata : cfg_points_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_points_r <= CFG_W'(2);
    end else begin
      cfg_points_r <= cfg_points_nxt;
    end
  end

  lintp_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_pop   (q_pop),
    .q_valid (q_valid),
    .q_item  (q_item),
    .stat    (fr_stat)
  );

  lintp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  lintp_back #(
    .MAX_POINTS (MAX_POINTS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_points (cfg_points_r),
    .q_valid    (q_valid),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .div_req    (div_req),
    .div_rsp    (div_rsp),
    .out_ch     (out_ch)
  );

  assign any_rail = (out_ch.main_lift == 16'sh7fff) || (out_ch.main_lift == 16'sh8000) ||
                    (out_ch.main_drag == 16'sh7fff) || (out_ch.main_drag == 16'sh8000) ||
                    (out_ch.back_lift == 16'sh7fff) || (out_ch.back_lift == 16'sh8000) ||
                    (out_ch.back_drag == 16'sh7fff) || (out_ch.back_drag == 16'sh8000);

  `TLIE_ASSERT(a_ready_after_reset, $past(!rst_n) |-> in_ch.ready, "queue not empty after reset")
  `TLIE_ASSERT(a_idle_after_reset, $past(!rst_n) |-> !out_ch.valid, "result valid after reset")
  `TLIE_NEVER(a_full_not_ready, fr_stat.full && in_ch.ready, "ready while queue full")
  `TLIE_ASSERT(a_sat_on_rail, out_ch.valid && out_ch.saturated |-> any_rail, "saturated off rail")
endmodule

// ----- design/lintp_front.sv -----
// Front end: accepts input transactions, tags writes and queries, and
// queues them for the back end. Depends on lintp_pkg and lintp_if.
module lintp_front (
  input  logic                 clk,
  input  logic                 rst_n,
  lintp_in_if.sink             in_ch,
  input  logic                 q_pop,
  output logic                 q_valid,
  output lintp_pkg::item_t     q_item,
  output lintp_pkg::front_stat_t stat
);
  import lintp_pkg::*;

  item_t             q_mem [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              push;
  item_t             new_item;

  assign in_ch.ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (cnt_r != '0);
  assign q_item      = q_mem[rp_r];
  assign stat.full   = (cnt_r == QCNT_W'(QDEPTH));

  always_comb begin
    new_item.is_query         = (in_ch.op == OP_QUERY);
    new_item.row_index        = in_ch.row_index;
    new_item.breakpoint_angle = in_ch.breakpoint_angle;
    new_item.vals[0]          = in_ch.main_lift_value;
    new_item.vals[1]          = in_ch.main_drag_value;
    new_item.vals[2]          = in_ch.back_lift_value;
    new_item.vals[3]          = in_ch.back_drag_value;
    new_item.query_angle      = in_ch.query_angle;
  end

  always_comb begin
    wp_nxt  = push ? wp_r + QPTR_W'(1) : wp_r;
    rp_nxt  = q_pop ? rp_r + QPTR_W'(1) : rp_r;
    cnt_nxt = cnt_r + QCNT_W'(push) - QCNT_W'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wp_r] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end
endmodule

// ----- design/lintp_div.sv -----
// Restoring divider, one quotient bit per cycle, for the segment fraction.
// Depends on lintp_pkg.
module lintp_div (
  input  logic                clk,
  input  logic                rst_n,
  input  lintp_pkg::div_req_t req,
  output lintp_pkg::div_rsp_t rsp
);
  import lintp_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [NUM_W-1:0]     acc_r, acc_nxt;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [DEN_W-1:0]     den_r, den_nxt;
  logic [DEN_W:0]       rem_sh;
  logic [DEN_W:0]       rem_sub;
  logic                 ge;

  assign rsp.done = done_r;
  assign rsp.quo  = acc_r;

  always_comb begin
    rem_sh   = {rem_r, acc_r[NUM_W-1]};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_sub  = rem_sh - {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(NUM_W);
      acc_nxt  = req.num;
      rem_nxt  = '0;
      den_nxt  = req.den;
    end else if (busy_r) begin
      acc_nxt = {acc_r[NUM_W-2:0], ge};
      rem_nxt = ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
  end
endmodule

// ----- design/lintp_back.sv -----
// Back end: table memories, segment search, fraction and column blend,
// and the result register. Depends on lintp_pkg, lintp_if and lintp_div.
module lintp_back #(
  parameter int MAX_POINTS = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [lintp_pkg::CFG_W-1:0] cfg_points,
  input  logic                       q_valid,
  input  lintp_pkg::item_t           q_item,
  output logic                       q_pop,
  output lintp_pkg::div_req_t        div_req,
  input  lintp_pkg::div_rsp_t        div_rsp,
  lintp_out_if.source                out_ch
);
  import lintp_pkg::*;

  localparam int AW  = (MAX_POINTS > 2) ? $clog2(MAX_POINTS) : 1;
  localparam int NW  = $clog2(MAX_POINTS + 1);
  localparam int EW0 = (NW > CFG_W) ? NW : CFG_W;
  localparam int EW  = (EW0 > ROW_W) ? EW0 : ROW_W;

  q16_t  bp_mem  [MAX_POINTS];
  vals_t val_mem [MAX_POINTS];
  q16_t  bp_rd_r;
  vals_t val_rd_r;

  back_state_t        state_r, state_nxt;
  item_t              item_r, item_nxt;
  logic [NW-1:0]      n_r, n_nxt;
  logic [AW-1:0]      idx_r, idx_nxt, i0_r, i0_nxt, i1_r, i1_nxt;
  q16_t               b0_r, b0_nxt, x0_r, x0_nxt;
  vals_t              y0_r, y0_nxt, y1_r, y1_nxt, res_r, res_nxt;
  logic               extra_r, extra_nxt, sat_r, sat_nxt, neg_r, neg_nxt;
  logic signed [T_W-1:0]    t_r, t_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [1:0]         col_r, col_nxt;
  logic               out_valid_r, out_valid_nxt;
  res_t               out_data_r, out_data_nxt;

  logic               mem_we;
  logic [AW-1:0]      rd_addr;
  logic [EW-1:0]      cfg_w, n_w, row_w;
  logic [NW-1:0]      n_m1, n_m2;
  q16_t               qx;
  logic signed [16:0] d_w, dx_w, dy_w;
  logic [16:0]        d_mag, dx_mag;
  logic [PROD_W-1:0]  p_mag, p_rnd;
  logic signed [Y_W-1:0] r_w, y_w;
  q16_t               y_sat;
  logic               y_clip;

  always_comb begin
    cfg_w = EW'(cfg_points);
    if (cfg_w < EW'(2)) begin
      n_w = EW'(2);
    end else if (cfg_w > EW'(MAX_POINTS)) begin
      n_w = EW'(MAX_POINTS);
    end else begin
      n_w = cfg_w;
    end
    row_w  = EW'(q_item.row_index);
    n_m1   = n_r - NW'(1);
    n_m2   = n_r - NW'(2);
    qx     = item_r.query_angle;
    d_w    = {bp_rd_r[15], bp_rd_r} - {x0_r[15], x0_r};
    dx_w   = {qx[15], qx} - {x0_r[15], x0_r};
    d_mag  = d_w[16] ? -d_w : d_w;
    dx_mag = dx_w[16] ? -dx_w : dx_w;
    dy_w   = {y1_r[col_r][15], y1_r[col_r]} - {y0_r[col_r][15], y0_r[col_r]};
    // round the blended step to nearest, ties away from zero
    p_mag  = prod_r[PROD_W-1] ? -prod_r : prod_r;
    p_rnd  = p_mag + PROD_W'(32768);
    r_w    = $signed(Y_W'(p_rnd[PROD_W-1:16]));
    if (prod_r[PROD_W-1]) begin
      r_w = -r_w;
    end
    y_w = $signed({{(Y_W-16){y0_r[col_r][15]}}, y0_r[col_r]}) + r_w;
    if (y_w > $signed(Y_W'(32767))) begin
      y_sat  = 16'sh7fff;
      y_clip = 1'b1;
    end else if (y_w < -$signed(Y_W'(32768))) begin
      y_sat  = 16'sh8000;
      y_clip = 1'b1;
    end else begin
      y_sat  = y_w[15:0];
      y_clip = 1'b0;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    item_nxt      = item_r;
    n_nxt         = n_r;
    idx_nxt       = idx_r;
    i0_nxt        = i0_r;
    i1_nxt        = i1_r;
    b0_nxt        = b0_r;
    x0_nxt        = x0_r;
    y0_nxt        = y0_r;
    y1_nxt        = y1_r;
    res_nxt       = res_r;
    extra_nxt     = extra_r;
    sat_nxt       = sat_r;
    neg_nxt       = neg_r;
    t_nxt         = t_r;
    prod_nxt      = prod_r;
    col_nxt       = col_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_data_nxt  = out_data_r;
    q_pop         = 1'b0;
    mem_we        = 1'b0;
    rd_addr       = '0;
    div_req.start = 1'b0;
    div_req.num   = {dx_mag[15:0], 16'd0} + NUM_W'(d_mag[16:1]);
    div_req.den   = d_mag[DEN_W-1:0];
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          item_nxt  = q_item;
          sat_nxt   = 1'b0;
          extra_nxt = 1'b0;
          if (q_item.is_query) begin
            n_nxt     = n_w[NW-1:0];
            state_nxt = B_FIRST;
          end else begin
            // out-of-range rows are dropped, the ack still goes out
            mem_we    = (row_w < EW'(MAX_POINTS));
            res_nxt   = '0;
            state_nxt = B_DONE;
          end
        end
      end
      B_FIRST: begin
        b0_nxt    = bp_rd_r;
        rd_addr   = n_m1[AW-1:0];
        state_nxt = B_LAST;
      end
      B_LAST: begin
        if (qx <= b0_r) begin
          i0_nxt    = '0;
          i1_nxt    = AW'(1);
          extra_nxt = (qx < b0_r);
          state_nxt = B_FETCH0;
        end else if (qx >= bp_rd_r) begin
          i0_nxt    = n_m2[AW-1:0];
          i1_nxt    = n_m1[AW-1:0];
          extra_nxt = (qx > bp_rd_r);
          state_nxt = B_FETCH0;
        end else begin
          idx_nxt   = AW'(1);
          rd_addr   = AW'(1);
          state_nxt = B_SCAN;
        end
      end
      B_SCAN: begin
        // last row in use lies above qx, so the scan stops by then
        if (bp_rd_r > qx) begin
          i1_nxt    = idx_r;
          i0_nxt    = idx_r - AW'(1);
          state_nxt = B_FETCH0;
        end else begin
          idx_nxt = idx_r + AW'(1);
          rd_addr = idx_r + AW'(1);
        end
      end
      B_FETCH0: begin
        rd_addr   = i0_r;
        state_nxt = B_FETCH1;
      end
      B_FETCH1: begin
        x0_nxt    = bp_rd_r;
        y0_nxt    = val_rd_r;
        rd_addr   = i1_r;
        state_nxt = B_FETCH2;
      end
      B_FETCH2: begin
        y1_nxt  = val_rd_r;
        col_nxt = '0;
        if (d_w == '0) begin
          t_nxt     = '0;
          state_nxt = B_MUL;
        end else begin
          div_req.start = 1'b1;
          neg_nxt       = dx_w[16] ^ d_w[16];
          state_nxt     = B_DIV;
        end
      end
      B_DIV: begin
        if (div_rsp.done) begin
          t_nxt     = $signed({1'b0, div_rsp.quo});
          if (neg_r) begin
            t_nxt = -$signed({1'b0, div_rsp.quo});
          end
          state_nxt = B_MUL;
        end
      end
      B_MUL: begin
        prod_nxt  = t_r * dy_w;
        state_nxt = B_ACC;
      end
      B_ACC: begin
        res_nxt[col_r] = y_sat;
        sat_nxt        = sat_r | y_clip;
        if (col_r == 2'd3) begin
          state_nxt = B_DONE;
        end else begin
          col_nxt   = col_r + 2'd1;
          state_nxt = B_MUL;
        end
      end
      B_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.vals         = res_r;
          out_data_nxt.saturated    = sat_r;
          out_data_nxt.extrapolated = extra_r;
          state_nxt                 = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      bp_mem[row_w[AW-1:0]]  <= q_item.breakpoint_angle;
      val_mem[row_w[AW-1:0]] <= q_item.vals;
    end
    bp_rd_r  <= bp_mem[rd_addr];
    val_rd_r <= val_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    n_r        <= n_nxt;
    idx_r      <= idx_nxt;
    i0_r       <= i0_nxt;
    i1_r       <= i1_nxt;
    b0_r       <= b0_nxt;
    x0_r       <= x0_nxt;
    y0_r       <= y0_nxt;
    y1_r       <= y1_nxt;
    res_r      <= res_nxt;
    extra_r    <= extra_nxt;
    sat_r      <= sat_nxt;
    neg_r      <= neg_nxt;
    t_r        <= t_nxt;
    prod_r     <= prod_nxt;
    col_r      <= col_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.main_lift    = out_data_r.vals[0];
  assign out_ch.main_drag    = out_data_r.vals[1];
  assign out_ch.back_lift    = out_data_r.vals[2];
  assign out_ch.back_drag    = out_data_r.vals[3];
  assign out_ch.saturated    = out_data_r.saturated;
  assign out_ch.extrapolated = out_data_r.extrapolated;
endmodule

// ----- dv/table_linear_interp_extrap_top_tb.sv -----
// Self-checking testbench for the four-column breakpoint table interpolator.
// Drives row loads, queries and points_in_use settings, predicts every result.
// Depends on lintp_pkg, lintp_if and table_linear_interp_extrap_top.
module table_linear_interp_extrap_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lintp_pkg::*;

  localparam int NUM_ROWS    = 64;
  localparam int DRAIN_WAIT  = 150;
  localparam int RANDOM_ITEMS = 1000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;

  lintp_in_if  in_ch ();
  lintp_out_if out_ch ();

  table_linear_interp_extrap_top #(.MAX_POINTS(NUM_ROWS)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Shadow copy of the block's table and register
  q16_t angle_tab [NUM_ROWS];
  vals_t value_tab [NUM_ROWS];
  logic [CFG_W-1:0] active_points = 7'd2;

  res_t pending_results[$];
  int mismatches = 0;
  bit in_quiet = 1'b0;
  bit out_quiet = 1'b0;
  int out_hold = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_WRITE;
    in_ch.row_index = '0;
    in_ch.breakpoint_angle = '0;
    in_ch.main_lift_value = '0;
    in_ch.main_drag_value = '0;
    in_ch.back_lift_value = '0;
    in_ch.back_drag_value = '0;
    in_ch.query_angle = '0;
    out_ch.ready = 1'b0;
  end

  // Round to nearest, ties away from zero
  function automatic longint round_div(longint num, longint den);
    longint un;
    longint ud;
    longint q;
    un = (num < 0) ? -num : num;
    ud = (den < 0) ? -den : den;
    q = (un + ud / 2) / ud;
    return ((num < 0) != (den < 0)) ? -q : q;
  endfunction

  function automatic res_t interpolate_item(item_t it);
    res_t r;
    int n;
    int x;
    int i0;
    int i1;
    longint x0;
    longint d;
    longint frac;
    longint y;
    r = '0;
    if (it.is_query == OP_WRITE) begin
      angle_tab[it.row_index] = it.breakpoint_angle;
      value_tab[it.row_index] = it.vals;
      return r;
    end
    n = active_points;
    if (n < 2) n = 2;
    if (n > NUM_ROWS) n = NUM_ROWS;
    x = it.query_angle;
    if (x <= angle_tab[0]) begin
      i0 = 0;
      i1 = 1;
      r.extrapolated = (x < angle_tab[0]);
    end else if (x >= angle_tab[n-1]) begin
      i0 = n - 2;
      i1 = n - 1;
      r.extrapolated = (x > angle_tab[n-1]);
    end else begin
      i1 = n - 1;
      for (int i = 1; i < n; i++) begin
        if (angle_tab[i] > x) begin
          i1 = i;
          break;
        end
      end
      i0 = i1 - 1;
    end
    x0 = angle_tab[i0];
    d = longint'(angle_tab[i1]) - x0;
    frac = (d != 0) ? round_div((x - x0) * 65536, d) : 0;
    for (int c = 0; c < 4; c++) begin
      y = longint'(value_tab[i0][c]) +
          round_div(frac * (longint'(value_tab[i1][c]) - longint'(value_tab[i0][c])), 65536);
      if (y > 32767) begin
        y = 32767;
        r.saturated = 1'b1;
      end else if (y < -32768) begin
        y = -32768;
        r.saturated = 1'b1;
      end
      r.vals[c] = y[15:0];
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (in_quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Entered and left at a falling edge; valid stays high for a back-to-back follower
  task automatic send_item(item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.op <= it.is_query;
    in_ch.row_index <= it.row_index;
    in_ch.breakpoint_angle <= it.breakpoint_angle;
    in_ch.main_lift_value <= it.vals[0];
    in_ch.main_drag_value <= it.vals[1];
    in_ch.back_lift_value <= it.vals[2];
    in_ch.back_drag_value <= it.vals[3];
    in_ch.query_angle <= it.query_angle;
    in_ch.valid <= 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    pending_results.insert(pending_results.size(), interpolate_item(it));
    @(negedge clk);
  endtask

  task automatic write_row(int row, int angle, vals_t v);
    item_t it;
    it = '0;
    it.is_query = OP_WRITE;
    it.row_index = row[ROW_W-1:0];
    it.breakpoint_angle = angle[15:0];
    it.vals = v;
    it.query_angle = q16_t'($urandom());
    send_item(it);
  endtask

  task automatic query_at(int angle);
    item_t it;
    logic [127:0] raw;
    raw = {$urandom(), $urandom(), $urandom(), $urandom()};
    it = raw[$bits(item_t)-1:0];
    it.is_query = OP_QUERY;
    it.query_angle = angle[15:0];
    send_item(it);
  endtask

  // Drop valid and wait until every transaction has come back and the engine is quiet
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic set_points(int value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value[CFG_W-1:0];
    active_points = value[CFG_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic vals_t random_vals();
    return vals_t'({$urandom(), $urandom()});
  endfunction

  // Load all rows with increasing angles starting at lo
  task automatic load_sorted_table(int lo);
    int step_max;
    int a;
    step_max = (32767 - lo) / (NUM_ROWS - 1);
    if (step_max < 1) step_max = 1;
    a = lo;
    for (int r = 0; r < NUM_ROWS; r++) begin
      write_row(r, a, random_vals());
      a += $urandom_range(1, step_max);
    end
  endtask

  task automatic test_table_load();
    vals_t v;
    load_sorted_table(-32768);
    v = {16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000};
    write_row(0, -32768, v);
    write_row(1, -32000, ~v);
    write_row(NUM_ROWS - 1, 32767, v);
  endtask

  task automatic test_directed_queries();
    vals_t v;
    // Reset setting: two rows, far extrapolation saturates
    query_at(-32768);
    query_at(-32000);
    query_at(-32400);
    query_at(32767);
    set_points(NUM_ROWS);
    query_at(32767);
    query_at(angle_tab[30]);
    query_at(angle_tab[30] + 1);
    query_at(angle_tab[NUM_ROWS-2] + 1);
    // Equal breakpoints on the first segment
    v = random_vals();
    write_row(1, -32768, v);
    query_at(-32768);
    query_at(-32767);
    write_row(1, -32000, random_vals());
    // Out-of-order row inside the span
    write_row(10, angle_tab[3] - 5, random_vals());
    query_at(angle_tab[9] + 1);
    query_at(angle_tab[12]);
    set_points(0);
    query_at(0);
    set_points(1);
    query_at(-32767);
    set_points(127);
    query_at(32000);
    set_points(65);
    query_at(12345);
  endtask

  task automatic test_random_traffic();
    int sent;
    int n;
    int lo;
    int hi;
    int a;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 150 == 0) begin
        case ($urandom_range(0, 4))
          0: set_points(2);
          1: set_points(NUM_ROWS);
          2: set_points($urandom_range(0, 127));
          default: set_points($urandom_range(2, 16));
        endcase
        if ($urandom_range(0, 2) != 0) load_sorted_table($urandom_range(0, 40000) - 32768);
        in_quiet = ($urandom_range(0, 3) == 0);
        out_quiet = ($urandom_range(0, 3) == 0);
      end
      n = (active_points < 2) ? 2 : (active_points > NUM_ROWS ? NUM_ROWS : active_points);
      if ($urandom_range(0, 99) < 20) begin
        // mostly keep order by landing between neighbors
        a = $urandom_range(0, NUM_ROWS - 1);
        if ($urandom_range(0, 3) == 0 || a == 0 || a == NUM_ROWS - 1)
          write_row(a, $urandom_range(0, 65535) - 32768, random_vals());
        else
          write_row(a, (int'(angle_tab[a-1]) + int'(angle_tab[a+1])) / 2, random_vals());
      end else begin
        lo = int'(angle_tab[0]) - 300;
        hi = int'(angle_tab[n-1]) + 300;
        if ($urandom_range(0, 99) < 30 || hi <= lo) a = $urandom_range(0, 65535) - 32768;
        else a = lo + $urandom_range(0, hi - lo);
        if (a < -32768) a = -32768;
        if (a > 32767) a = 32767;
        query_at(a);
      end
      if ($urandom_range(0, 199) == 0) drain();
      sent++;
    end
  endtask

  // Result side stalls: mostly short, a few long holds, some stretches with none
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold <= out_hold - 1;
      out_ch.ready <= 1'b0;
    end else if (out_quiet || !rst_n) begin
      out_ch.ready <= rst_n;
    end else if ($urandom_range(0, 99) < 3) begin
      out_hold <= $urandom_range(10, 50);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) < 70);
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result transaction");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("main_lift", want.vals[0], out_ch.main_lift);
        check_field("main_drag", want.vals[1], out_ch.main_drag);
        check_field("back_lift", want.vals[2], out_ch.back_lift);
        check_field("back_drag", want.vals[3], out_ch.back_drag);
        check_field("saturated", want.saturated, out_ch.saturated);
        check_field("extrapolated", want.extrapolated, out_ch.extrapolated);
      end
    end
  end

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_table_load();
    test_directed_queries();
    test_random_traffic();
    drain();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #25ms;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
